@@ rtl/core/assert_macros.svh @@
// assertion helpers for the allocator top level
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define SSFL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define SSFL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/ssfl_pkg.sv @@
// types and constants of the size sorted free list allocator
// no dependencies; used by ssfl_cell and the top level
`timescale 1ns / 1ps
`default_nettype none
package ssfl_pkg;
   localparam int LIST_DEPTH_DEF = 64;
   localparam int ADDR_BITS_DEF = 32;
   localparam int FIELD_BITS = 32;
   localparam int LIMIT_BITS = 7;
   localparam int USED_BITS = 7;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd64;
   localparam int MIN_REMAINDER = 8;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_NO_FIT = 2'd2;

   localparam logic CMD_FREE = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   typedef struct packed {
      logic insert;
      logic drop;
   } cell_ctl_type;
endpackage
`default_nettype wire

@@ rtl/core/ssfl_cell.sv @@
// one free-list entry: compares its size with the key, shifts up on insert
// and down on drop; depends on ssfl_pkg
`timescale 1ns / 1ps
`default_nettype none
module ssfl_cell
   import ssfl_pkg::*;
#(
   parameter int ADDR_BITS = ADDR_BITS_DEF,
   parameter int CNT_BITS = 7,
   parameter int IDX = 0
) (
   input  wire logic                 clock,
   input  wire cell_ctl_type         ctl,
   input  wire logic [CNT_BITS-1:0]  count,
   input  wire logic [ADDR_BITS-1:0] key,
   input  wire logic [ADDR_BITS-1:0] new_off,
   input  wire logic                 prev_mark,
   input  wire logic [ADDR_BITS-1:0] prev_off,
   input  wire logic [ADDR_BITS-1:0] prev_size,
   input  wire logic [ADDR_BITS-1:0] next_off,
   input  wire logic [ADDR_BITS-1:0] after_size,
   input  wire logic                 drop_here,
   output logic                      valid,
   output logic                      mark,
   output logic [ADDR_BITS-1:0]      off,
   output logic [ADDR_BITS-1:0]      size
);
   logic [ADDR_BITS-1:0] off_ff, off_in, size_ff, size_in;

   assign valid = count > CNT_BITS'(IDX);
   // at or after the first entry whose size reaches the key
   assign mark = !(valid && (size_ff < key));
   assign off = off_ff;
   assign size = size_ff;

   always_comb begin
      off_in = off_ff;
      size_in = size_ff;
      if (ctl.insert && mark) begin
         if (prev_mark) begin
            off_in = prev_off;
            size_in = prev_size;
         end else begin
            off_in = new_off;
            size_in = key;
         end
      end else if (ctl.drop && drop_here) begin
         off_in = next_off;
         size_in = after_size;
      end
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in;
      size_ff <= size_in;
   end
endmodule
`default_nettype wire

@@ rtl/core/size_sorted_free_list_allocator_unit.sv @@
// top level of the size sorted free list allocator: sequencer plus cell row
// depends on ssfl_pkg, ssfl_cell and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Usage
//  Command port: drive req_command (0 free, 1 allocate), req_block_offset and
//  req_block_size with start high; the transfer happens at an edge where
//  busy is low. busy stays high until the response has been shown.
//  Response: rsp_valid is high for exactly one cycle with rsp_status,
//  rsp_granted_offset and rsp_entries_used; the receiver cannot stall it.
//  Config: csr_entry_limit is written when csr_valid and csr_ready are high;
//  csr_ready is always high. Write it only while busy is low.
//  Timing: a free runs lookup, decide, insert and response, without insert
//  when the list is full; an allocate runs lookup, decide and response, and
//  repeats lookup and decide and adds insert when a split remainder is put
//  back. All cells compare in parallel with the key and shift by one
//  position. One command is in flight at a time, so a new command is taken
//  the cycle after the response.
//  Reset: synchronous; the list empties and the limit returns to 64.
module size_sorted_free_list_allocator_unit
   import ssfl_pkg::*;
#(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF,
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_command,
   input  wire logic [FIELD_BITS-1:0] req_block_offset,
   input  wire logic [FIELD_BITS-1:0] req_block_size,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status,
   output logic [FIELD_BITS-1:0]      rsp_granted_offset,
   output logic [USED_BITS-1:0]       rsp_entries_used,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [LIMIT_BITS-1:0] csr_entry_limit
);
   localparam int CNT_BITS = $clog2(LIST_DEPTH + 1);
   localparam int LW = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FIND = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_INSERT = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic cmd_ff, cmd_in, refree_ff, refree_in, found_ff, found_in;
   logic [ADDR_BITS-1:0] off_ff, off_in, key_ff, key_in;
   logic [ADDR_BITS-1:0] hit_off_ff, hit_off_in, hit_size_ff, hit_size_in;
   logic [ADDR_BITS-1:0] granted_ff, granted_in;
   logic [LIST_DEPTH-1:0] dropmask_ff, dropmask_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;
   logic [1:0] status_ff, status_in;

   cell_ctl_type ctl;
   logic [LIST_DEPTH-1:0] valid_v, mark_v, first_v;
   logic [ADDR_BITS-1:0] c_off [LIST_DEPTH];
   logic [ADDR_BITS-1:0] c_size [LIST_DEPTH];
   logic [ADDR_BITS-1:0] mux_off, mux_size, rem, end_addr;
   logic [ADDR_BITS:0] merged_sum;
   logic [LW-1:0] limit_eff;
   logic at_limit, can_merge;

   genvar g;
   generate
      for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
         logic pmark;
         logic [ADDR_BITS-1:0] poff, psize, noff, nsize;
         if (g == 0) begin : g_first
            assign pmark = 1'b0;
            assign poff = '0;
            assign psize = '0;
         end else begin : g_mid
            assign pmark = mark_v[g-1];
            assign poff = c_off[g-1];
            assign psize = c_size[g-1];
         end
         if (g == LIST_DEPTH - 1) begin : g_last
            assign noff = c_off[g];
            assign nsize = c_size[g];
         end else begin : g_inner
            assign noff = c_off[g+1];
            assign nsize = c_size[g+1];
         end
         ssfl_cell #(.ADDR_BITS(ADDR_BITS), .CNT_BITS(CNT_BITS), .IDX(g)) u_cell (
            .clock(clock), .ctl(ctl), .count(count_ff), .key(key_ff),
            .new_off(off_ff), .prev_mark(pmark), .prev_off(poff), .prev_size(psize),
            .next_off(noff), .after_size(nsize), .drop_here(dropmask_ff[g]),
            .valid(valid_v[g]), .mark(mark_v[g]), .off(c_off[g]), .size(c_size[g])
         );
      end
   endgenerate

   // one-hot of the first fitting position, and its contents
   always_comb begin
      mux_off = '0;
      mux_size = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         first_v[i] = mark_v[i] && valid_v[i] && ((i == 0) || !mark_v[(i == 0) ? 0 : i-1]);
         if (first_v[i]) begin
            mux_off = mux_off | c_off[i];
            mux_size = mux_size | c_size[i];
         end
      end
   end

   assign limit_eff = (LW'(limit_ff) < LW'(LIST_DEPTH)) ? LW'(limit_ff) : LW'(LIST_DEPTH);
   assign at_limit = LW'(count_ff) >= limit_eff;
   assign end_addr = off_ff + key_ff;
   assign merged_sum = {1'b0, key_ff} + {1'b0, hit_size_ff};
   assign can_merge = found_ff && (end_addr == hit_off_ff) && !merged_sum[ADDR_BITS];
   assign rem = hit_size_ff - key_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      refree_in = refree_ff;
      found_in = found_ff;
      off_in = off_ff;
      key_in = key_ff;
      hit_off_in = hit_off_ff;
      hit_size_in = hit_size_ff;
      granted_in = granted_ff;
      dropmask_in = dropmask_ff;
      count_in = count_ff;
      limit_in = limit_ff;
      status_in = status_ff;
      ctl = '0;
      if (csr_valid) limit_in = csr_entry_limit;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in = req_command;
               refree_in = 1'b0;
               off_in = ADDR_BITS'(req_block_offset);
               key_in = ADDR_BITS'(req_block_size);
               granted_in = '0;
               status_in = STATUS_OK;
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            found_in = |first_v;
            hit_off_in = mux_off;
            hit_size_in = mux_size;
            dropmask_in = mark_v;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (cmd_ff == CMD_FREE || refree_ff) begin
               if (!refree_ff && at_limit) begin
                  status_in = STATUS_FULL;
                  state_in = ST_DONE;
               end else begin
                  if (can_merge) begin
                     // merged entry leaves its slot and is reinserted by size
                     ctl.drop = 1'b1;
                     count_in = count_ff - 1'b1;
                     key_in = merged_sum[ADDR_BITS-1:0];
                  end
                  state_in = ST_INSERT;
               end
            end else if (!found_ff) begin
               status_in = STATUS_NO_FIT;
               state_in = ST_DONE;
            end else if (rem == '0) begin
               ctl.drop = 1'b1;
               count_in = count_ff - 1'b1;
               granted_in = hit_off_ff;
               state_in = ST_DONE;
            end else if (rem < ADDR_BITS'(MIN_REMAINDER) || at_limit) begin
               status_in = STATUS_NO_FIT;
               state_in = ST_DONE;
            end else begin
               ctl.drop = 1'b1;
               count_in = count_ff - 1'b1;
               granted_in = hit_off_ff;
               off_in = hit_off_ff + key_ff;
               key_in = rem;
               refree_in = 1'b1;
               state_in = ST_FIND;
            end
         end
         ST_INSERT: begin
            ctl.insert = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         limit_ff <= limit_in;
      end
      cmd_ff <= cmd_in;
      refree_ff <= refree_in;
      found_ff <= found_in;
      off_ff <= off_in;
      key_ff <= key_in;
      hit_off_ff <= hit_off_in;
      hit_size_ff <= hit_size_in;
      granted_ff <= granted_in;
      dropmask_ff <= dropmask_in;
      status_ff <= status_in;
   end

   assign busy = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = state_ff == ST_DONE;
   assign rsp_status = status_ff;
   assign rsp_granted_offset = FIELD_BITS'(granted_ff);
   assign rsp_entries_used = USED_BITS'(count_ff);

   `SSFL_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "response held two cycles")
   `SSFL_ASSERT(a_count_range, clock, reset, count_ff <= CNT_BITS'(LIST_DEPTH), "count beyond depth")
   `SSFL_ASSERT(a_insert_room, clock, reset, (state_ff == ST_INSERT) |-> (count_ff < CNT_BITS'(LIST_DEPTH)), "insert into full list")
   `SSFL_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accepted command left block idle")
endmodule
`default_nettype wire
